// ===== sv/polyphase_q15_resampler_defines.svh =====
// Shared assertion macros for the resampler checker.
`ifndef POLYPHASE_Q15_RESAMPLER_DEFINES_SVH
`define POLYPHASE_Q15_RESAMPLER_DEFINES_SVH

// Property checked on every rising edge, switched off while reset is high.
`define PQR_ASSERT(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("resampler port assertion failed");

// Property checked on every rising edge, reset included.
`define PQR_ASSERT_ALWAYS(label, clk, prop) \
   label: assert property (@(posedge clk) prop) \
      else $error("resampler reset assertion failed");

`endif

// ===== sv/pqr_pkg.sv =====
package pqr_pkg;

   localparam int NUM_TAPS_DEF   = 128;
   localparam int HIST_DEPTH_DEF = 256;

   localparam int SAMPLE_W    = 16;
   localparam int COEF_IDX_W  = 7;
   localparam int UP_W        = 5;
   localparam int DOWN_W      = 16;
   localparam int TAPS_W      = 8;
   localparam int PHASE_W     = 4;
   localparam int MAX_UP      = 16;
   localparam int MAX_RUN     = 16;
   localparam int RUN_W       = 4;
   // Largest coefficient address: row 15 times 255 taps plus tap 254.
   localparam int COEF_ADDR_W = 12;
   localparam int PROD_W      = 32;
   localparam int ACC_W       = 40;
   localparam int Q_SHIFT     = 15;
   localparam int SAT_MAX     = 32767;
   localparam int SAT_MIN     = -32768;
   // Phase plus down factor needs one bit more than the down factor.
   localparam int SUM_W       = 17;
   localparam int DIV_CNT_W   = 5;

   localparam int CSR_IDX_W   = 2;
   localparam int CSR_DATA_W  = 16;

   localparam int UP_RESET    = 1;
   localparam int DOWN_RESET  = 1;
   localparam int TAPS_RESET  = 128;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_UP_FACTOR      = 2'd0,
      CSR_DOWN_FACTOR    = 2'd1,
      CSR_TAPS_PER_PHASE = 2'd2
   } csr_index_type;

   typedef enum logic {
      REQ_SAMPLE = 1'b0,
      REQ_COEF   = 1'b1
   } req_kind_type;

endpackage

// ===== sv/pqr_if.sv =====
interface pqr_req_if import pqr_pkg::*; ();
   logic                         valid;
   logic                         ready;
   logic                         req_type;
   logic signed [SAMPLE_W-1:0]   sample_in;
   logic [COEF_IDX_W-1:0]        coef_index;
   logic signed [SAMPLE_W-1:0]   coef_value;

   modport source (output valid, output req_type, output sample_in, output coef_index,
                   output coef_value, input ready);
   modport sink (input valid, input req_type, input sample_in, input coef_index,
                 input coef_value, output ready);
endinterface

interface pqr_rsp_if import pqr_pkg::*; ();
   logic                         valid;
   logic                         ready;
   logic signed [SAMPLE_W-1:0]   sample_out;
   logic                         last_of_run;

   modport source (output valid, output sample_out, output last_of_run, input ready);
   modport sink (input valid, input sample_out, input last_of_run, output ready);
endinterface

interface pqr_csr_if import pqr_pkg::*; ();
   logic                         valid;
   logic                         ready;
   logic [CSR_IDX_W-1:0]         index;
   logic [CSR_DATA_W-1:0]        data;

   modport source (output valid, output index, output data, input ready);
   modport sink (input valid, input index, input data, output ready);
endinterface

// ===== sv/polyphase_q15_resampler.sv =====
// Rational L/M polyphase resampler for signed 16-bit audio with Q15 coefficients.
// A sample request goes into a history ring; every output whose newest input is
// that sample then follows as a run of results, the last one flagged with
// last_of_run. A coefficient request writes one coefficient table entry and gives
// no result. Each output is one multiply-accumulate pass of P = taps_per_phase
// taps through one shared multiplier, which reads one history word and one
// coefficient per cycle from two memories, each with its own write and read
// port. An output cannot finish before the 17-step phase divider that runs
// beside the tap loop has finished. A sample request causes up to 16 outputs;
// coefficient requests and skipped samples are taken without starting a run.
// A finished result waits in an output register, so the next request is taken
// while it is still unread. Configuration writes are taken in any cycle but must
// only come while the block is idle. The history ring reads as zero until
// written, tracked by a fill count; coefficient entries must be written before
// any output uses them.
module polyphase_q15_resampler import pqr_pkg::*; #(
   parameter int NUM_TAPS   = NUM_TAPS_DEF,
   parameter int HIST_DEPTH = HIST_DEPTH_DEF
) (
   input  logic       clock,
   input  logic       reset,
   pqr_req_if.sink    req_ch,
   pqr_rsp_if.source  rsp_ch,
   pqr_csr_if.sink    csr_ch
);

   localparam int COEF_AW = $clog2(NUM_TAPS);
   localparam int HIST_AW = $clog2(HIST_DEPTH);
   localparam int FILL_W  = $clog2(HIST_DEPTH + 1);
   localparam int CMP_W   = (FILL_W > TAPS_W) ? FILL_W : TAPS_W;

   localparam logic [HIST_AW-1:0]     HIST_LAST  = HIST_AW'(HIST_DEPTH - 1);
   localparam logic [FILL_W-1:0]      FILL_FULL  = FILL_W'(HIST_DEPTH);
   localparam logic [COEF_ADDR_W-1:0] COEF_LIMIT = COEF_ADDR_W'(NUM_TAPS);
   localparam logic signed [ACC_W-1:0] ACC_MAX   = ACC_W'(SAT_MAX);
   localparam logic signed [ACC_W-1:0] ACC_MIN   = ACC_W'(SAT_MIN);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_START,
      ST_MAC,
      ST_DRAIN,
      ST_OUT
   } state_type;

   // Storage.
   logic signed [SAMPLE_W-1:0] hist_mem [HIST_DEPTH];
   logic signed [SAMPLE_W-1:0] coef_mem [NUM_TAPS];

   // Control registers.
   state_type                 state_ff, state_in;
   logic [UP_W-1:0]           up_ff, up_in;
   logic [DOWN_W-1:0]         down_ff, down_in;
   logic [TAPS_W-1:0]         taps_ff, taps_in;
   logic [HIST_AW-1:0]        wpos_ff, wpos_in;
   logic [FILL_W-1:0]         fill_ff, fill_in;
   logic [PHASE_W-1:0]        phase_ff, phase_in;
   logic [DOWN_W-1:0]         wait_ff, wait_in;
   logic [RUN_W-1:0]          run_ff, run_in;
   logic [TAPS_W-1:0]         tap_ff, tap_in;
   logic [HIST_AW-1:0]        hidx_ff, hidx_in;
   logic [COEF_ADDR_W-1:0]    caddr_ff, caddr_in;
   logic                      s1_vld_ff, s1_vld_in;
   logic                      s1_mask_ff, s1_mask_in;
   logic                      s2_vld_ff, s2_vld_in;
   logic [SUM_W-1:0]          div_num_ff, div_num_in;
   logic [SUM_W-1:0]          div_quo_ff, div_quo_in;
   logic [PHASE_W-1:0]        div_rem_ff, div_rem_in;
   logic [DIV_CNT_W-1:0]      div_cnt_ff, div_cnt_in;
   logic                      rsp_vld_ff, rsp_vld_in;

   // Datapath registers.
   logic signed [SAMPLE_W-1:0] hist_rd_ff;
   logic signed [SAMPLE_W-1:0] coef_rd_ff;
   logic signed [PROD_W-1:0]   prod_ff, prod_in;
   logic signed [ACC_W-1:0]    acc_ff, acc_in;
   logic signed [SAMPLE_W-1:0] rsp_data_ff, rsp_data_in;
   logic                       rsp_last_ff, rsp_last_in;

   // Combinational helpers.
   logic                       req_fire;
   logic                       sample_fire;
   logic                       coef_fire;
   logic                       coef_we;
   logic [COEF_AW-1:0]         coef_wa;
   logic [COEF_AW-1:0]         coef_ra;
   logic                       coef_in_range;
   logic                       tap_valid;
   logic [UP_W-1:0]            up_eff;
   logic [DOWN_W-1:0]          down_eff;
   logic [SUM_W-1:0]           div_sum;
   logic [PHASE_W:0]           div_try;
   logic                       div_ge;
   logic [PHASE_W-1:0]         div_rem_next;
   logic signed [PROD_W-1:0]   mult_full;
   logic signed [ACC_W-1:0]    acc_shift;
   logic signed [SAMPLE_W-1:0] sat_out;
   logic                       run_last;
   logic                       out_free;

   // Handshakes. Requests are taken only between runs; the output register
   // lets the next request in while the last result is still unread.
   assign req_ch.ready = (state_ff == ST_IDLE);
   assign csr_ch.ready = 1'b1;
   assign rsp_ch.valid       = rsp_vld_ff;
   assign rsp_ch.sample_out  = rsp_data_ff;
   assign rsp_ch.last_of_run = rsp_last_ff;

   assign req_fire    = req_ch.valid && req_ch.ready;
   assign sample_fire = req_fire && (req_ch.req_type == REQ_SAMPLE);
   assign coef_fire   = req_fire && (req_ch.req_type == REQ_COEF);
   // Coefficient writes beyond the table are dropped.
   assign coef_we     = coef_fire && (COEF_ADDR_W'(req_ch.coef_index) < COEF_LIMIT);
   assign coef_wa     = COEF_AW'(req_ch.coef_index);

   // Taps whose coefficient address runs past the table contribute nothing,
   // as do history entries that were never written since reset.
   assign coef_in_range = (caddr_ff < COEF_LIMIT);
   assign coef_ra       = coef_in_range ? caddr_ff[COEF_AW-1:0] : '0;
   assign tap_valid     = (fill_ff == FILL_FULL) || (CMP_W'(tap_ff) < CMP_W'(fill_ff));

   // Out-of-range factors are clamped: L to 1..16, M zero to one.
   always_comb begin
      if (up_ff == '0) begin
         up_eff = UP_W'(1);
      end else if (up_ff > UP_W'(MAX_UP)) begin
         up_eff = UP_W'(MAX_UP);
      end else begin
         up_eff = up_ff;
      end
   end
   assign down_eff = (down_ff == '0) ? DOWN_W'(1) : down_ff;

   // Phase step (phase + M) / L as a restoring divider, one quotient bit
   // per cycle, running alongside the tap loop.
   assign div_sum      = SUM_W'(phase_ff) + SUM_W'(down_eff);
   assign div_try      = {div_rem_ff, div_num_ff[SUM_W-1]};
   assign div_ge       = (div_try >= up_eff);
   assign div_rem_next = div_ge ? PHASE_W'(div_try - up_eff) : PHASE_W'(div_try);

   // Multiplier and output scaling: floor shift by 15, then saturation.
   assign mult_full = hist_rd_ff * coef_rd_ff;
   assign acc_shift = acc_ff >>> Q_SHIFT;
   always_comb begin
      if (acc_shift > ACC_MAX) begin
         sat_out = SAMPLE_W'(SAT_MAX);
      end else if (acc_shift < ACC_MIN) begin
         sat_out = SAMPLE_W'(SAT_MIN);
      end else begin
         sat_out = acc_shift[SAMPLE_W-1:0];
      end
   end

   // A run ends once the next output needs a newer sample, or after 16 outputs.
   assign run_last = (div_quo_ff != '0) || (run_ff == RUN_W'(MAX_RUN - 1));
   assign out_free = !rsp_vld_ff || rsp_ch.ready;

   always_comb begin
      state_in    = state_ff;
      up_in       = up_ff;
      down_in     = down_ff;
      taps_in     = taps_ff;
      wpos_in     = wpos_ff;
      fill_in     = fill_ff;
      phase_in    = phase_ff;
      wait_in     = wait_ff;
      run_in      = run_ff;
      tap_in      = tap_ff;
      hidx_in     = hidx_ff;
      caddr_in    = caddr_ff;
      div_num_in  = div_num_ff;
      div_quo_in  = div_quo_ff;
      div_rem_in  = div_rem_ff;
      div_cnt_in  = div_cnt_ff;
      rsp_vld_in  = rsp_vld_ff;
      rsp_data_in = rsp_data_ff;
      rsp_last_in = rsp_last_ff;
      acc_in      = acc_ff;

      // Multiply-accumulate pipeline: read, multiply, accumulate.
      s1_vld_in  = (state_ff == ST_MAC);
      s1_mask_in = coef_in_range && tap_valid;
      s2_vld_in  = s1_vld_ff;
      prod_in    = s1_mask_ff ? mult_full : '0;
      if (s2_vld_ff) begin
         acc_in = acc_ff + {{(ACC_W - PROD_W){prod_ff[PROD_W-1]}}, prod_ff};
      end

      if (div_cnt_ff != '0) begin
         div_rem_in = div_rem_next;
         div_quo_in = {div_quo_ff[SUM_W-2:0], div_ge};
         div_num_in = div_num_ff << 1;
         div_cnt_in = div_cnt_ff - DIV_CNT_W'(1);
      end

      if (rsp_vld_ff && rsp_ch.ready) begin
         rsp_vld_in = 1'b0;
      end

      if (csr_ch.valid) begin
         case (csr_ch.index)
            CSR_UP_FACTOR: begin
               up_in = csr_ch.data[UP_W-1:0];
            end
            CSR_DOWN_FACTOR: begin
               down_in = csr_ch.data[DOWN_W-1:0];
            end
            CSR_TAPS_PER_PHASE: begin
               taps_in = csr_ch.data[TAPS_W-1:0];
            end
            default: begin
            end
         endcase
      end

      case (state_ff)
         ST_IDLE: begin
            if (sample_fire) begin
               wpos_in = (wpos_ff == HIST_LAST) ? '0 : HIST_AW'(wpos_ff + 1'b1);
               if (fill_ff != FILL_FULL) begin
                  fill_in = FILL_W'(fill_ff + 1'b1);
               end
               // Samples that are not the newest input of the next output
               // only go into the ring.
               if (wait_ff != '0) begin
                  wait_in = DOWN_W'(wait_ff - 1'b1);
               end else begin
                  run_in   = '0;
                  state_in = ST_START;
               end
            end
         end
         ST_START: begin
            tap_in     = '0;
            hidx_in    = (wpos_ff == '0) ? HIST_LAST : HIST_AW'(wpos_ff - 1'b1);
            caddr_in   = COEF_ADDR_W'(phase_ff) * COEF_ADDR_W'(taps_ff);
            acc_in     = '0;
            div_num_in = div_sum;
            div_quo_in = '0;
            div_rem_in = '0;
            div_cnt_in = DIV_CNT_W'(SUM_W);
            state_in   = (taps_ff == '0) ? ST_DRAIN : ST_MAC;
         end
         ST_MAC: begin
            tap_in   = TAPS_W'(tap_ff + 1'b1);
            hidx_in  = (hidx_ff == '0) ? HIST_LAST : HIST_AW'(hidx_ff - 1'b1);
            caddr_in = COEF_ADDR_W'(caddr_ff + 1'b1);
            if (tap_ff == TAPS_W'(taps_ff - 1'b1)) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            if (!s1_vld_ff && !s2_vld_ff && (div_cnt_ff == '0)) begin
               state_in = ST_OUT;
            end
         end
         ST_OUT: begin
            if (out_free) begin
               rsp_vld_in  = 1'b1;
               rsp_data_in = sat_out;
               rsp_last_in = run_last;
               phase_in    = div_rem_ff;
               if (div_quo_ff != '0) begin
                  wait_in = DOWN_W'(div_quo_ff - 1'b1);
               end
               run_in   = RUN_W'(run_ff + 1'b1);
               state_in = run_last ? ST_IDLE : ST_START;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Sequencer state and the registered result.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_IDLE;
         up_ff      <= UP_W'(UP_RESET);
         down_ff    <= DOWN_W'(DOWN_RESET);
         taps_ff    <= TAPS_W'(TAPS_RESET);
         wpos_ff    <= '0;
         fill_ff    <= '0;
         phase_ff   <= '0;
         wait_ff    <= '0;
         run_ff     <= '0;
         tap_ff     <= '0;
         hidx_ff    <= '0;
         caddr_ff   <= '0;
         s1_vld_ff  <= 1'b0;
         s1_mask_ff <= 1'b0;
         s2_vld_ff  <= 1'b0;
         div_num_ff <= '0;
         div_quo_ff <= '0;
         div_rem_ff <= '0;
         div_cnt_ff <= '0;
         rsp_vld_ff <= 1'b0;
      end else begin
         state_ff   <= state_in;
         up_ff      <= up_in;
         down_ff    <= down_in;
         taps_ff    <= taps_in;
         wpos_ff    <= wpos_in;
         fill_ff    <= fill_in;
         phase_ff   <= phase_in;
         wait_ff    <= wait_in;
         run_ff     <= run_in;
         tap_ff     <= tap_in;
         hidx_ff    <= hidx_in;
         caddr_ff   <= caddr_in;
         s1_vld_ff  <= s1_vld_in;
         s1_mask_ff <= s1_mask_in;
         s2_vld_ff  <= s2_vld_in;
         div_num_ff <= div_num_in;
         div_quo_ff <= div_quo_in;
         div_rem_ff <= div_rem_in;
         div_cnt_ff <= div_cnt_in;
         rsp_vld_ff <= rsp_vld_in;
      end
      rsp_data_ff <= rsp_data_in;
      rsp_last_ff <= rsp_last_in;
   end

   // Arithmetic registers; their contents only matter under the valid flags.
   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
      acc_ff  <= acc_in;
   end

   // History ring: written on sample requests, read once per tap. The write
   // and the first read of a run fall in different cycles.
   always_ff @(posedge clock) begin
      if (sample_fire) begin
         hist_mem[wpos_ff] <= req_ch.sample_in;
      end
      hist_rd_ff <= hist_mem[hidx_ff];
   end

   // Coefficient table.
   always_ff @(posedge clock) begin
      if (coef_we) begin
         coef_mem[coef_wa] <= req_ch.coef_value;
      end
      coef_rd_ff <= coef_mem[coef_ra];
   end

endmodule

// ===== sv/pqr_checker.sv =====
`include "polyphase_q15_resampler_defines.svh"

module pqr_checker import pqr_pkg::*; (
   input logic                       clock,
   input logic                       reset,
   input logic                       req_ready,
   input logic                       rsp_valid,
   input logic                       rsp_ready,
   input logic signed [SAMPLE_W-1:0] rsp_sample_out,
   input logic                       rsp_last_of_run
);

   // A result that is not taken stays offered and unchanged.
   `PQR_ASSERT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready |=> rsp_valid)
   `PQR_ASSERT(a_rsp_stable, clock, reset, rsp_valid && !rsp_ready |=> $stable(rsp_sample_out) && $stable(rsp_last_of_run))

   // A new result only appears out of a run, when requests were held off.
   `PQR_ASSERT(a_rsp_from_run, clock, reset, $rose(rsp_valid) |-> !$past(req_ready))

   // Reset leaves the block idle with nothing to deliver.
   `PQR_ASSERT_ALWAYS(a_reset_idle, clock, reset |=> !rsp_valid && req_ready)

endmodule

bind polyphase_q15_resampler pqr_checker u_pqr_checker (
   .clock           (clock),
   .reset           (reset),
   .req_ready       (req_ch.ready),
   .rsp_valid       (rsp_ch.valid),
   .rsp_ready       (rsp_ch.ready),
   .rsp_sample_out  (rsp_ch.sample_out),
   .rsp_last_of_run (rsp_ch.last_of_run)
);
